### hw/rtl/range_list_slot_allocator_assert.svh
// Assertion macros for the range list slot allocator checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RANGE_LIST_SLOT_ALLOCATOR_ASSERT_SVH
`define RANGE_LIST_SLOT_ALLOCATOR_ASSERT_SVH

// checked only out of reset
`define RLSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rlsa: port check failed");

// checked at every edge, reset included
`define RLSA_ASSERT_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rlsa: reset check failed");

`endif

### hw/rtl/rlsa_pkg.sv
// Shared types and codes of the range list slot allocator.
// No dependencies; used by the front, back and top level.
package rlsa_pkg;

  localparam int HEAP_W = 3;
  localparam int SLOT_W = 12;
  localparam int CFG_W  = 13;
  localparam logic [CFG_W-1:0] SPH_RESET = 13'd4096;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_HEAP   = 2'd1;
  localparam logic [1:0] ST_LIST_FULL = 2'd2;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HEAP_W-1:0] heap;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

### hw/rtl/rlsa_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module rlsa_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rlsa_front.sv
// Front end: takes input beats, decodes the action and queues commands.
// Depends on rlsa_pkg.
module rlsa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [2:0]         in_heap_index,
  input  logic [11:0]        in_slot_index,
  output rlsa_pkg::cmd_chan_t cmd_o,
  input  logic               cmd_pop
);

  rlsa_pkg::cmd_t q_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  rlsa_pkg::cmd_t cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    cmd_in.op   = in_action ? rlsa_pkg::OP_RELEASE : rlsa_pkg::OP_ALLOC;
    cmd_in.heap = in_heap_index;
    cmd_in.slot = in_slot_index;
  end

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ cmd_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  assign cmd_o.valid = (cnt_r != 2'd0);
  assign cmd_o.cmd   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

### hw/rtl/rlsa_back.sv
// Back end: sequencer over the range RAM, per-heap counts and result register.
// Depends on rlsa_pkg and rlsa_ram.
module rlsa_back #(
  parameter int MAX_HEAPS  = 8,
  parameter int MAX_RANGES = 16,
  parameter int MAX_SLOTS  = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rlsa_pkg::cmd_chan_t cmd_i,
  output logic                cmd_pop,
  input  logic                cfg_valid,
  input  logic [12:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [2:0]          out_got_heap,
  output logic [11:0]         out_got_slot
);

  localparam int HW    = MAX_HEAPS > 1 ? $clog2(MAX_HEAPS) : 1;
  localparam int OW    = $clog2(MAX_HEAPS + 1);
  localparam int RW    = MAX_RANGES > 1 ? $clog2(MAX_RANGES) : 1;
  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int VW    = $clog2(MAX_SLOTS + 1) > 13 ? $clog2(MAX_SLOTS + 1) : 13;
  localparam int DEPTH = MAX_HEAPS * MAX_RANGES;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CMPW  = OW > 3 ? OW : 3;

  typedef enum logic [8:0] {
    S_INIT = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_ARD  = 9'b000000100,
    S_ACHK = 9'b000001000,
    S_SHRD = 9'b000010000,
    S_SHWR = 9'b000100000,
    S_RRD  = 9'b001000000,
    S_RCHK = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [HW-1:0]   h_r, h_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [11:0]     slot_r, slot_nxt;
  logic [CW-1:0]   cnt_r [MAX_HEAPS];
  logic [CW-1:0]   cnt_nxt [MAX_HEAPS];
  logic [OW-1:0]   ho_r, ho_nxt;
  logic [12:0]     sph_r, sph_nxt;
  logic [1:0]      res_status_r, res_status_nxt;
  logic [2:0]      res_heap_r, res_heap_nxt;
  logic [11:0]     res_slot_r, res_slot_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [2:0]      out_heap_r, out_heap_nxt;
  logic [11:0]     out_slot_r, out_slot_nxt;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*VW-1:0] wdata, rdata;
  logic [VW-1:0]   rd_begin, rd_end, slot_v;
  logic            found;
  logic [HW-1:0]   found_h;
  logic [HW-1:0]   ho_h;

  function automatic logic [VW-1:0] clamp_size(input logic [12:0] v);
    logic [VW-1:0] w;
    w = VW'(v);
    if (v == 13'd0) begin
      return VW'(1);
    end else if (w > VW'(MAX_SLOTS)) begin
      return VW'(MAX_SLOTS);
    end
    return w;
  endfunction

  function automatic logic [AW-1:0] ent(input logic [HW-1:0] h, input logic [CW-1:0] i);
    logic [RW-1:0] ii;
    ii = RW'(i);
    return AW'(h) * AW'(MAX_RANGES) + AW'(ii);
  endfunction

  rlsa_ram #(
    .WIDTH(2 * VW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_begin = rdata[2*VW-1:VW];
  assign rd_end   = rdata[VW-1:0];
  assign slot_v   = VW'(slot_r);
  assign ho_h     = HW'(ho_r);

  // lowest open heap with a nonempty list
  always_comb begin
    found   = 1'b0;
    found_h = '0;
    for (int i = 0; i < MAX_HEAPS; i++) begin
      if (!found && (OW'(i) < ho_r) && (cnt_r[i] != '0)) begin
        found   = 1'b1;
        found_h = HW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    h_nxt          = h_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    ho_nxt         = ho_r;
    sph_nxt        = cfg_valid ? cfg_data : sph_r;
    res_status_nxt = res_status_r;
    res_heap_nxt   = res_heap_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_heap_nxt   = out_heap_r;
    out_slot_nxt   = out_slot_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    raddr          = '0;
    cmd_pop        = 1'b0;

    case (state_r)
      S_INIT: begin
        // heap 0 starts with its full range
        we        = 1'b1;
        waddr     = '0;
        wdata     = {VW'(0), clamp_size(rlsa_pkg::SPH_RESET)};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop        = 1'b1;
          res_status_nxt = rlsa_pkg::ST_DONE;
          res_heap_nxt   = '0;
          res_slot_nxt   = '0;
          if (cmd_i.cmd.op == rlsa_pkg::OP_ALLOC) begin
            if (found) begin
              h_nxt     = found_h;
              state_nxt = S_ARD;
            end else if (ho_r >= OW'(MAX_HEAPS)) begin
              res_status_nxt = rlsa_pkg::ST_NO_HEAP;
              state_nxt      = S_FIN;
            end else begin
              we            = 1'b1;
              waddr         = ent(ho_h, '0);
              wdata         = {VW'(0), clamp_size(sph_r)};
              cnt_nxt[ho_h] = CW'(1);
              ho_nxt        = ho_r + OW'(1);
              h_nxt         = ho_h;
              state_nxt     = S_ARD;
            end
          end else begin
            if (CMPW'(cmd_i.cmd.heap) >= CMPW'(ho_r)) begin
              state_nxt = S_FIN;
            end else begin
              h_nxt     = HW'(cmd_i.cmd.heap);
              slot_nxt  = cmd_i.cmd.slot;
              idx_nxt   = '0;
              state_nxt = S_RRD;
            end
          end
        end
      end
      S_ARD: begin
        raddr     = ent(h_r, '0);
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        res_heap_nxt = 3'(h_r);
        res_slot_nxt = rd_begin[11:0];
        if (rd_begin + VW'(1) < rd_end) begin
          we        = 1'b1;
          waddr     = ent(h_r, '0);
          wdata     = {rd_begin + VW'(1), rd_end};
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = CW'(1);
          state_nxt = S_SHRD;
        end
      end
      S_SHRD: begin
        // front range used up: move later ranges down one place
        if (idx_r == cnt_r[h_r]) begin
          cnt_nxt[h_r] = cnt_r[h_r] - CW'(1);
          state_nxt    = S_FIN;
        end else begin
          raddr     = ent(h_r, idx_r);
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        we        = 1'b1;
        waddr     = ent(h_r, idx_r - CW'(1));
        wdata     = rdata;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SHRD;
      end
      S_RRD: begin
        if (idx_r == cnt_r[h_r]) begin
          if (cnt_r[h_r] >= CW'(MAX_RANGES)) begin
            res_status_nxt = rlsa_pkg::ST_LIST_FULL;
          end else begin
            we           = 1'b1;
            waddr        = ent(h_r, cnt_r[h_r]);
            wdata        = {slot_v, slot_v + VW'(1)};
            cnt_nxt[h_r] = cnt_r[h_r] + CW'(1);
          end
          state_nxt = S_FIN;
        end else begin
          raddr     = ent(h_r, idx_r);
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (slot_v == rd_end) begin
          we        = 1'b1;
          waddr     = ent(h_r, idx_r);
          wdata     = {rd_begin, rd_end + VW'(1)};
          state_nxt = S_FIN;
        end else if (slot_v + VW'(1) == rd_begin) begin
          we        = 1'b1;
          waddr     = ent(h_r, idx_r);
          wdata     = {rd_begin - VW'(1), rd_end};
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_RRD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_heap_nxt   = res_heap_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ho_r        <= OW'(1);
      sph_r       <= rlsa_pkg::SPH_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_HEAPS; i++) begin
        cnt_r[i] <= (i == 0) ? CW'(1) : '0;
      end
    end else begin
      state_r     <= state_nxt;
      ho_r        <= ho_nxt;
      sph_r       <= sph_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    h_r          <= h_nxt;
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_heap_r   <= res_heap_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_heap_r   <= out_heap_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_got_heap = out_heap_r;
  assign out_got_slot = out_slot_r;

endmodule

### hw/rtl/range_list_slot_allocator.sv
// Range list slot allocator: hands out slots from per-heap lists of free
// ranges and takes them back. A two-entry command queue decouples input
// from the sequencer, and a result register parts the output. Work per
// item is set by the sequencer's range RAM (one write, one read port):
// an allocate hands out the first slot of a heap's front range, moving
// later ranges down when that range empties; a release widens a range
// next to the slot or adds one. Reset first writes heap 0's initial range.
// Depends on rlsa_pkg, rlsa_front, rlsa_back and rlsa_ram.
module range_list_slot_allocator #(
  parameter int MAX_HEAPS  = 8,
  parameter int MAX_RANGES = 16,
  parameter int MAX_SLOTS  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [2:0]  in_heap_index,
  input  logic [11:0] in_slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_got_heap,
  output logic [11:0] out_got_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  rlsa_pkg::cmd_chan_t cmd;
  logic                cmd_pop;

  assign cfg_ready = 1'b1;

  rlsa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_heap_index(in_heap_index),
    .in_slot_index(in_slot_index),
    .cmd_o        (cmd),
    .cmd_pop      (cmd_pop)
  );

  rlsa_back #(
    .MAX_HEAPS (MAX_HEAPS),
    .MAX_RANGES(MAX_RANGES),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .cmd_pop     (cmd_pop),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_got_heap(out_got_heap),
    .out_got_slot(out_got_slot)
  );

endmodule

### hw/rtl/rlsa_checker.sv
// Port-level checks for the range list slot allocator, bound to the top.
// Depends on range_list_slot_allocator_assert.svh and rlsa_pkg.
`include "range_list_slot_allocator_assert.svh"

module rlsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [2:0]  out_got_heap,
  input logic [11:0] out_got_slot
);

  logic [16:0] out_beat;

  assign out_beat = {out_status, out_got_heap, out_got_slot};

  `RLSA_ASSERT_ANY(a_no_result_after_reset, !rst_n |=> !out_valid)
  `RLSA_ASSERT(a_result_held, out_valid && out_stall |=> out_valid && $stable(out_beat))
  `RLSA_ASSERT(a_no_heap_zero, out_valid && out_status == rlsa_pkg::ST_NO_HEAP |-> out_beat[14:0] == '0)
  `RLSA_ASSERT(a_status_code, out_valid |-> out_status <= rlsa_pkg::ST_LIST_FULL)

endmodule

bind range_list_slot_allocator rlsa_checker u_rlsa_checker (.*);
